// File: src/fibm_pkg.sv
// Shared constants and control/status types for the Fibonacci mod 1000 block.
// No dependencies; used by every module of the block.
package fibm_pkg;

    // Default width of the index field
    localparam int INDEX_BITS_DEF = 31;

    // Modulus and entry width
    localparam int FIB_MODULUS = 1000;
    localparam int MOD_W       = 10;

    // Width of one product entry sum: two 10x10 products added
    localparam int PROD_W = 2 * MOD_W;
    localparam int SUM_W  = PROD_W + 1;

    // Reciprocal of the modulus for the quotient estimate, floor(2^31 / 1000)
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / FIB_MODULUS);
    localparam int RPROD_W     = SUM_W + RECIP_W;
    localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // take a new index, set matrix to identity
        logic mul;       // form the squared entry sums
        logic red;       // estimate quotients by the modulus
        logic fix;       // finish reduction, apply Q step, shift index
        logic load_out;  // move result into output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
    } t_sts;

endpackage

// File: src/fibonacci_mod_1000_matrix_power.sv
// Fibonacci number modulo 1000 by 2x2 matrix square-and-multiply.
// Top level: joins fibm_ctrl and fibm_dp; depends on fibm_pkg.
//
// Usage:
//   Input channel i_index_valid / o_index_ready carries one index word.
//   Output channel o_fib_valid / i_fib_ready returns F(index) mod 1000.
//   One result word per index word, in order.
// Timing:
//   Each index bit passes through the shared matrix unit in three steps:
//   square (entry products), quotient estimate, then remainder and Q step.
//   A new index is taken only after the result of the last one has
//   entered the output register, so one index is worked on at a time.
// Reset:
//   Synchronous, active low; the controller returns to idle and the output
//   register is emptied. Matrix registers are loaded on acceptance.
// Stall:
//   The output register holds a finished word while the receiver stalls,
//   and the next index is still accepted and worked on; a second finished
//   word waits in the datapath until the output register is free.
module fibonacci_mod_1000_matrix_power #(
    parameter int INDEX_BITS = fibm_pkg::INDEX_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_index_valid,
    output logic                       o_index_ready,
    input  logic [INDEX_BITS-1:0]      i_index,
    output logic                       o_fib_valid,
    input  logic                       i_fib_ready,
    output logic [fibm_pkg::MOD_W-1:0] o_fib_mod
);

    fibm_pkg::t_cmd w_cmd;
    fibm_pkg::t_sts w_sts;

    fibm_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_index_valid (i_index_valid),
        .o_index_ready (o_index_ready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    fibm_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_index     (i_index),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_fib_mod   (o_fib_mod),
        .o_fib_valid (o_fib_valid),
        .i_fib_ready (i_fib_ready)
    );

endmodule

// File: src/fibm_ctrl.sv
// Controller state machine for the Fibonacci mod 1000 block.
// Depends on fibm_pkg for the command and status types.
module fibm_ctrl #(
    parameter int INDEX_BITS = fibm_pkg::INDEX_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_index_valid,
    output logic           o_index_ready,
    input  fibm_pkg::t_sts i_sts,
    output fibm_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(INDEX_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_RED  = 5'b00100,
        S_FIX  = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_bit, n_bit;

    // Next state and bit counter
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_index_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit      = CNT_W'(INDEX_BITS - 1);
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RED;
            end
            S_RED: begin
                o_cmd.red = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_HOLD;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_HOLD: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_index_ready = (r_state == S_IDLE);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

endmodule

// File: src/fibm_dp.sv
// Datapath for the Fibonacci mod 1000 block: matrix registers, modular
// reduction, index shifter and output register. Depends on fibm_pkg.
module fibm_dp #(
    parameter int INDEX_BITS = fibm_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [INDEX_BITS-1:0]        i_index,
    input  fibm_pkg::t_cmd               i_cmd,
    output fibm_pkg::t_sts               o_sts,
    output logic [fibm_pkg::MOD_W-1:0]   o_fib_mod,
    output logic                         o_fib_valid,
    input  logic                         i_fib_ready
);

    localparam int MW = fibm_pkg::MOD_W;
    localparam int SW = fibm_pkg::SUM_W;
    localparam int QW = fibm_pkg::QUOT_W;
    localparam int RW = fibm_pkg::RPROD_W;

    // Matrix held row-major: [0]=a [1]=b [2]=c [3]=d
    logic [MW-1:0]         r_m [4];
    logic [SW-1:0]         r_s [4];
    logic [QW-1:0]         r_q [4];
    logic [INDEX_BITS-1:0] r_idx;
    logic [MW-1:0]         r_out;
    logic                  r_out_valid;

    logic [SW-1:0] n_s [4];
    logic [QW-1:0] n_q [4];
    logic [MW-1:0] w_red [4];
    logic [MW-1:0] n_m [4];
    logic [RW-1:0] w_rprod [4];
    logic [SW-1:0] w_qm [4];
    logic [SW-1:0] w_rem [4];
    logic [MW:0]   w_ab, w_cd;
    logic [MW-1:0] w_ab_mod, w_cd_mod;

    // Squaring: entry sums of m * m
    always_comb begin
        n_s[0] = SW'(r_m[0] * r_m[0]) + SW'(r_m[1] * r_m[2]);
        n_s[1] = SW'(r_m[0] * r_m[1]) + SW'(r_m[1] * r_m[3]);
        n_s[2] = SW'(r_m[2] * r_m[0]) + SW'(r_m[3] * r_m[2]);
        n_s[3] = SW'(r_m[2] * r_m[1]) + SW'(r_m[3] * r_m[3]);
    end

    // Quotient estimate by reciprocal; low by at most one
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rprod[i] = RW'(r_s[i]) * RW'(fibm_pkg::RECIP);
            n_q[i]     = QW'(w_rprod[i] >> fibm_pkg::RECIP_SHIFT);
        end
    end

    // Remainder with one correction; q*1000 as shifts and subtractions
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_qm[i]  = (SW'(r_q[i]) << 10) - (SW'(r_q[i]) << 4) - (SW'(r_q[i]) << 3);
            w_rem[i] = r_s[i] - w_qm[i];
            if (w_rem[i] >= SW'(fibm_pkg::FIB_MODULUS)) begin
                w_red[i] = MW'(w_rem[i] - SW'(fibm_pkg::FIB_MODULUS));
            end else begin
                w_red[i] = MW'(w_rem[i]);
            end
        end
    end

    // Multiply by Q = [[1,1],[1,0]] when the current index bit is set
    always_comb begin
        w_ab = {1'b0, w_red[0]} + {1'b0, w_red[1]};
        w_cd = {1'b0, w_red[2]} + {1'b0, w_red[3]};
        w_ab_mod = (w_ab >= (MW+1)'(fibm_pkg::FIB_MODULUS))
                 ? MW'(w_ab - (MW+1)'(fibm_pkg::FIB_MODULUS)) : MW'(w_ab);
        w_cd_mod = (w_cd >= (MW+1)'(fibm_pkg::FIB_MODULUS))
                 ? MW'(w_cd - (MW+1)'(fibm_pkg::FIB_MODULUS)) : MW'(w_cd);
        if (r_idx[INDEX_BITS-1]) begin
            n_m[0] = w_ab_mod;
            n_m[1] = w_red[0];
            n_m[2] = w_cd_mod;
            n_m[3] = w_red[2];
        end else begin
            n_m = w_red;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m[0] <= MW'(1);
            r_m[1] <= '0;
            r_m[2] <= '0;
            r_m[3] <= MW'(1);
            r_idx  <= i_index;
        end else if (i_cmd.fix) begin
            r_m   <= n_m;
            r_idx <= r_idx << 1;
        end
        if (i_cmd.mul) begin
            r_s <= n_s;
        end
        if (i_cmd.red) begin
            r_q <= n_q;
        end
        if (i_cmd.load_out) begin
            r_out <= r_m[1];
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_fib_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_fib_ready;
    assign o_fib_mod      = r_out;
    assign o_fib_valid    = r_out_valid;

endmodule

// File: src/fibm_checker.sv
// Port-level checks for the Fibonacci mod 1000 block, bound to the top level.
// Depends on fibm_pkg for the modulus and word width.
module fibm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_index_valid,
    input logic                       o_index_ready,
    input logic                       o_fib_valid,
    input logic                       i_fib_ready,
    input logic [fibm_pkg::MOD_W-1:0] o_fib_mod
);

    // Output word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fib_valid && !i_fib_ready |=> o_fib_valid && $stable(o_fib_mod))
        else $error("output word dropped or changed while stalled");

    // Result always a residue of the modulus
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fib_valid |-> o_fib_mod < fibm_pkg::MOD_W'(fibm_pkg::FIB_MODULUS))
        else $error("result not below modulus");

    // Block is busy for at least the cycle after taking an index
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_index_valid && o_index_ready |=> !o_index_ready)
        else $error("index taken while previous one in progress");

    // No result word straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_fib_valid)
        else $error("output valid after reset");

endmodule

bind fibonacci_mod_1000_matrix_power fibm_checker u_fibm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_index_valid (i_index_valid),
    .o_index_ready (o_index_ready),
    .o_fib_valid   (o_fib_valid),
    .i_fib_ready   (i_fib_ready),
    .o_fib_mod     (o_fib_mod)
);

// File: bench/fib_mod_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Fibonacci mod 1000 block: watches both channels and predicts each result.
// Depends on fibm_pkg for the index and result widths.
module fib_mod_checker #(
    parameter int INDEX_W = fibm_pkg::INDEX_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_index_valid,
    input  logic                       i_index_ready,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic                       i_fib_valid,
    input  logic                       i_fib_ready,
    input  logic [fibm_pkg::MOD_W-1:0] i_fib_mod,
    output int                         o_error_count,
    output int                         o_pending
);

    localparam int unsigned FIB_MOD = 1000;

    // F(n) mod 1000 from Q^n, Q = [[1,1],[1,0]], bits scanned from the top
    function automatic logic [fibm_pkg::MOD_W-1:0] fib_mod_1000_of(
        input logic [INDEX_W-1:0] n
    );
        int unsigned a, b, c, d, ta, tb, tc, td;
        a = 1; b = 0; c = 0; d = 1;
        for (int k = INDEX_W - 1; k >= 0; k--) begin
            ta = (a * a + b * c) % FIB_MOD;
            tb = (a * b + b * d) % FIB_MOD;
            tc = (c * a + d * c) % FIB_MOD;
            td = (c * b + d * d) % FIB_MOD;
            a = ta; b = tb; c = tc; d = td;
            // times Q: rows become (a+b, a) and (c+d, c)
            if (n[k]) begin
                ta = (a + b) % FIB_MOD;
                tc = (c + d) % FIB_MOD;
                b  = a;
                d  = c;
                a  = ta;
                c  = tc;
            end
        end
        return b[fibm_pkg::MOD_W-1:0];
    endfunction

    logic [fibm_pkg::MOD_W-1:0] expected_fib[$];
    logic [fibm_pkg::MOD_W-1:0] want;

    // Predict on each accepted index word, compare on each accepted result word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_error_count <= 0;
            o_pending     <= 0;
        end else begin
            if (i_index_valid && i_index_ready)
                expected_fib.push_back(fib_mod_1000_of(i_index));
            if (i_fib_valid && i_fib_ready) begin
                if (expected_fib.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0d",
                             $time, i_fib_mod);
                    o_error_count <= o_error_count + 1;
                end else begin
                    want = expected_fib.pop_front();
                    if (i_fib_mod !== want) begin
                        $display("%0t: fib_mod mismatch, expected %0d, actual %0d",
                                 $time, want, i_fib_mod);
                        o_error_count <= o_error_count + 1;
                    end
                end
            end
            o_pending <= expected_fib.size();
        end
    end

endmodule

// File: bench/tb_fibonacci_mod_1000_matrix_power.sv
`timescale 1ns / 100ps
// Top of the bench: clock, reset, index stimulus with idle phases and the verdict.
// Depends on fibm_pkg, fibonacci_mod_1000_matrix_power and fib_mod_checker.
module tb_fibonacci_mod_1000_matrix_power;

    localparam int INDEX_W      = fibm_pkg::INDEX_BITS_DEF;
    localparam int RANDOM_WORDS = 285;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       index_valid   = 1'b0;
    logic [INDEX_W-1:0]         index_word    = '0;
    logic                       fib_ready     = 1'b0;
    logic                       index_ready;
    logic                       fib_valid;
    logic [fibm_pkg::MOD_W-1:0] fib_mod;
    int                         error_count;
    int                         pending;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    fibonacci_mod_1000_matrix_power #(
        .INDEX_BITS(INDEX_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_index_valid(index_valid),
        .o_index_ready(index_ready),
        .i_index      (index_word),
        .o_fib_valid  (fib_valid),
        .i_fib_ready  (fib_ready),
        .o_fib_mod    (fib_mod)
    );

    fib_mod_checker #(
        .INDEX_W(INDEX_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_index_valid(index_valid),
        .i_index_ready(index_ready),
        .i_index      (index_word),
        .i_fib_valid  (fib_valid),
        .i_fib_ready  (fib_ready),
        .i_fib_mod    (fib_mod),
        .o_error_count(error_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls at the current rate
    always @(posedge i_clk) begin
        fib_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One index word; valid only drops for an idle gap
    task automatic send_index(input logic [INDEX_W-1:0] n);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            index_valid <= 1'b0;
            @(posedge i_clk);
        end
        index_valid <= 1'b1;
        index_word  <= n;
        do @(posedge i_clk); while (!index_ready);
    endtask

    // Mix of full-width, small, random-width and Pisano-period-aligned indices
    function automatic logic [INDEX_W-1:0] random_index();
        logic [31:0] r;
        int          w;
        r = $urandom;
        w = $urandom_range(1, INDEX_W);
        case ($urandom_range(3))
            0: r = r;
            1: r = $urandom_range(0, 3000);
            2: r = r & ((32'd1 << w) - 1);
            default: r = 1500 * $urandom_range(0, 1431655) + $urandom_range(0, 3);
        endcase
        return r[INDEX_W-1:0];
    endfunction

    // Zero, first terms, indices around 1500 (Pisano period), extremes and bit patterns
    logic [INDEX_W-1:0] directed[] = '{
        0, 1, 2, 3, 10, 12, 15, 16, 100, 750, 999, 1000, 1499, 1500, 1501, 3000,
        31'h7FFF_FFFF, 31'h4000_0000, 31'h0000_0001, 31'h5555_5555, 31'h2AAA_AAAA,
        31'h7FFF_FFFE, 31'h0000_FFFF, 31'h7FFF_0000
    };

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_index(directed[k]);

        // Phases: no idling, sender idle, receiver stalling, both lightly
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            repeat (RANDOM_WORDS) send_index(random_index());
        end
        index_valid <= 1'b0;

        // Count is registered after each accept, so step first
        do @(posedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
